### hw/rtl/preset_length_winder_control_assert.svh
// Assertion macros used by plwc_step.
`ifndef PRESET_LENGTH_WINDER_CONTROL_ASSERT_SVH
`define PRESET_LENGTH_WINDER_CONTROL_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PLWC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("plwc assertion failed");

// Next-cycle implication, checked outside reset
`define PLWC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("plwc assertion failed");

`endif

### hw/rtl/plwc_pkg.sv
package plwc_pkg;

  // Width of the internal pulse counter
  localparam int COUNT_BITS = 24;
  localparam int TGT_BITS   = 24;
  localparam int CMP_W      = (COUNT_BITS > TGT_BITS) ? COUNT_BITS : TGT_BITS;
  localparam int CFG_DW     = 24;
  localparam int CFG_AW     = 2;

  // Register indexes of the configuration port
  typedef enum logic [CFG_AW-1:0] {
    REG_TARGET   = 2'd0,
    REG_BEEP_TOT = 2'd1,
    REG_BEEP_LEN = 2'd2,
    REG_GAP_LEN  = 2'd3
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [TGT_BITS-1:0] TARGET_RST   = 24'd165011;
  localparam logic [3:0]          BEEP_TOT_RST = 4'd3;
  localparam logic [15:0]         BEEP_LEN_RST = 16'd300;
  localparam logic [7:0]          GAP_LEN_RST  = 8'd150;

  localparam logic [7:0] GAP_MAX = 8'hFF;

  // LED codes
  localparam logic [3:0] LED_IDLE  = 4'b0101;
  localparam logic [3:0] LED_START = 4'b1111;
  localparam logic [3:0] LED_STOP  = 4'b0000;
  localparam logic [3:0] LED_BAR0  = 4'b0000;
  localparam logic [3:0] LED_BAR1  = 4'b0001;
  localparam logic [3:0] LED_BAR2  = 4'b0011;
  localparam logic [3:0] LED_BAR3  = 4'b0111;
  localparam logic [3:0] LED_BAR4  = 4'b1111;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_BUTTON = 2'd1,
    CAUSE_TARGET = 2'd2
  } stop_cause_t;

  typedef struct packed {
    logic [TGT_BITS-1:0] target_pulses;
    logic [3:0]          beep_total;
    logic [15:0]         beep_len_ms;
    logic [7:0]          gap_len_ms;
  } cfg_t;

  typedef struct packed {
    logic       ms_tick;
    logic [3:0] enc_delta;
    logic       button_press;
  } item_t;

  // Bargraph: floor(4*capped/target) steps, found by compares against
  // target, 2*target, 3*target and 4*target. capped never exceeds target.
  function automatic logic [3:0] bar_leds(input logic [TGT_BITS-1:0] capped,
                                          input logic [TGT_BITS-1:0] tgt);
    logic [TGT_BITS+1:0] q4;
    logic [TGT_BITS+1:0] t1;
    logic [TGT_BITS+1:0] t2;
    logic [TGT_BITS+1:0] t3;
    logic [TGT_BITS+1:0] t4;
    logic [3:0]          leds;
    q4 = {capped, 2'b00};
    t1 = {2'b00, tgt};
    t2 = {1'b0, tgt, 1'b0};
    t3 = t1 + t2;
    t4 = {tgt, 2'b00};
    if (tgt == '0) leds = LED_BAR0;
    else if (q4 >= t4) leds = LED_BAR4;
    else if (q4 >= t3) leds = LED_BAR3;
    else if (q4 >= t2) leds = LED_BAR2;
    else if (q4 >= t1) leds = LED_BAR1;
    else leds = LED_BAR0;
    return leds;
  endfunction

endpackage

### hw/rtl/plwc_in_if.sv
// Input channel: one loop step per request
interface plwc_in_if;
  logic       valid;
  logic       ready;
  logic       ms_tick;
  logic [3:0] enc_delta;
  logic       button_press;

  modport source (output valid, ms_tick, enc_delta, button_press, input ready);
  modport sink (input valid, ms_tick, enc_delta, button_press, output ready);
endinterface

### hw/rtl/plwc_out_if.sv
// Result channel: one result per step
interface plwc_out_if;
  logic        valid;
  logic        ready;
  logic        winding;
  logic        relay_drive;
  logic [3:0]  led_pattern;
  logic        buzzer_on;
  logic [23:0] wound_count;
  logic [1:0]  stop_cause;

  modport source (output valid, winding, relay_drive, led_pattern, buzzer_on,
                  wound_count, stop_cause, input ready);
  modport sink (input valid, winding, relay_drive, led_pattern, buzzer_on,
                wound_count, stop_cause, output ready);
endinterface

### hw/rtl/plwc_cfg.sv
module plwc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [plwc_pkg::CFG_AW-1:0] cfg_idx,
  input  logic [plwc_pkg::CFG_DW-1:0] cfg_wdata,
  output plwc_pkg::cfg_t              cfg
);
  import plwc_pkg::*;

  cfg_t cfg_r;

  // Register file, written one register per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_pulses <= TARGET_RST;
      cfg_r.beep_total    <= BEEP_TOT_RST;
      cfg_r.beep_len_ms   <= BEEP_LEN_RST;
      cfg_r.gap_len_ms    <= GAP_LEN_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_TARGET:   cfg_r.target_pulses <= cfg_wdata[TGT_BITS-1:0];
        REG_BEEP_TOT: cfg_r.beep_total    <= cfg_wdata[3:0];
        REG_BEEP_LEN: cfg_r.beep_len_ms   <= cfg_wdata[15:0];
        REG_GAP_LEN:  cfg_r.gap_len_ms    <= cfg_wdata[7:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/plwc_in_reg.sv
module plwc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  plwc_in_if.sink           in_ch,
  input  logic              take,
  output logic              item_valid,
  output plwc_pkg::item_t   item
);
  import plwc_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  logic  acc;

  // Accept when empty or when the held request moves on this cycle
  assign in_ch.ready = !vld_r || take;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (acc) vld_nxt = 1'b1;
    else if (take) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register
  always_ff @(posedge clk) begin
    if (acc) begin
      item_r.ms_tick      <= in_ch.ms_tick;
      item_r.enc_delta    <= in_ch.enc_delta;
      item_r.button_press <= in_ch.button_press;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

### hw/rtl/plwc_step.sv
`include "preset_length_winder_control_assert.svh"

module plwc_step (
  input  logic            clk,
  input  logic            rst_n,
  input  plwc_pkg::cfg_t  cfg,
  input  logic            item_valid,
  input  plwc_pkg::item_t item,
  output logic            take,
  plwc_out_if.source      out_ch
);
  import plwc_pkg::*;

  // Controller state
  logic                  mode_r,    mode_nxt;
  logic [COUNT_BITS-1:0] pc_r,      pc_nxt;
  logic [3:0]            beeps_r,   beeps_nxt;
  logic                  in_gap_r,  in_gap_nxt;
  logic [7:0]            gap_r,     gap_nxt;
  logic [15:0]           buzz_r,    buzz_nxt;

  // Result register
  logic                  out_vld_r;
  logic                  winding_r;
  logic [3:0]            leds_r;
  logic                  buzzer_r;
  logic [23:0]           wound_r;
  stop_cause_t           cause_r;

  logic [15:0]           buzz1;
  logic [7:0]            gap1;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] pc1;
  logic [CMP_W-1:0]      pc1_ext;
  logic [CMP_W-1:0]      tgt_ext;
  logic [CMP_W-1:0]      capped;
  logic [CMP_W-1:0]      pc_nxt_ext;
  logic [3:0]            leds;
  stop_cause_t           cause;

  // Step moves when the result register is free or drains this cycle
  assign take = item_valid && (!out_vld_r || out_ch.ready);

  // Tick, then saturating count
  always_comb begin
    buzz1 = buzz_r;
    if (item.ms_tick && buzz_r != '0) buzz1 = buzz_r - 16'd1;
    gap1 = gap_r;
    if (item.ms_tick && in_gap_r && gap_r != GAP_MAX) gap1 = gap_r + 8'd1;
    sum = {1'b0, pc_r} + {{(COUNT_BITS - 3){1'b0}}, item.enc_delta};
    pc1 = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
  end

  assign pc1_ext = CMP_W'(pc1);
  assign tgt_ext = CMP_W'(cfg.target_pulses);
  assign capped  = (pc1_ext < tgt_ext) ? pc1_ext : tgt_ext;

  // Mode and beep sequencer
  always_comb begin
    mode_nxt   = mode_r;
    pc_nxt     = pc1;
    beeps_nxt  = beeps_r;
    in_gap_nxt = in_gap_r;
    gap_nxt    = gap1;
    buzz_nxt   = buzz1;
    leds       = LED_IDLE;
    cause      = CAUSE_NONE;
    if (!mode_r) begin
      // beep-gap sequence runs only in idle
      if (in_gap_r) begin
        if (gap1 >= cfg.gap_len_ms) begin
          in_gap_nxt = 1'b0;
          if (beeps_r != '0) begin
            beeps_nxt = beeps_r - 4'd1;
            buzz_nxt  = cfg.beep_len_ms;
          end
        end
      end else if (beeps_r != '0 && buzz1 == '0) begin
        in_gap_nxt = 1'b1;
        gap_nxt    = '0;
      end
      // start: cancel beeps, clear count
      if (item.button_press) begin
        beeps_nxt  = '0;
        in_gap_nxt = 1'b0;
        buzz_nxt   = '0;
        mode_nxt   = 1'b1;
        pc_nxt     = '0;
        leds       = LED_START;
      end
    end else begin
      leds = bar_leds(capped[TGT_BITS-1:0], cfg.target_pulses);
      if (item.button_press) cause = CAUSE_BUTTON;
      else if (pc1_ext >= tgt_ext) cause = CAUSE_TARGET;
      // stop: begin beeping, zero beep total counts as one
      if (cause != CAUSE_NONE) begin
        mode_nxt   = 1'b0;
        leds       = LED_STOP;
        beeps_nxt  = (cfg.beep_total == '0) ? 4'd0 : cfg.beep_total - 4'd1;
        in_gap_nxt = 1'b0;
        buzz_nxt   = cfg.beep_len_ms;
      end
    end
  end

  assign pc_nxt_ext = CMP_W'(pc_nxt);

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      pc_r      <= '0;
      beeps_r   <= '0;
      in_gap_r  <= 1'b0;
      gap_r     <= '0;
      buzz_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (take) begin
        mode_r   <= mode_nxt;
        pc_r     <= pc_nxt;
        beeps_r  <= beeps_nxt;
        in_gap_r <= in_gap_nxt;
        gap_r    <= gap_nxt;
        buzz_r   <= buzz_nxt;
      end
      if (take) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      winding_r <= mode_nxt;
      leds_r    <= leds;
      buzzer_r  <= (buzz_nxt != '0);
      wound_r   <= pc_nxt_ext[23:0];
      cause_r   <= cause;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.winding     = winding_r;
  assign out_ch.relay_drive = winding_r;
  assign out_ch.led_pattern = leds_r;
  assign out_ch.buzzer_on   = buzzer_r;
  assign out_ch.wound_count = wound_r;
  assign out_ch.stop_cause  = cause_r;

  // Beeping is cancelled on start and cannot restart while winding
  `PLWC_ASSERT_IMPL(a_quiet_winding, clk, rst_n, mode_r,
                    beeps_r == '0 && !in_gap_r && buzz_r == '0)
  // A start step leaves winding with a cleared count
  `PLWC_ASSERT_NEXT(a_start_clears, clk, rst_n, take && !mode_r && item.button_press,
                    mode_r && pc_r == '0)
  // A reported stop always shows idle and dark LEDs
  `PLWC_ASSERT_IMPL(a_stop_result, clk, rst_n, out_vld_r && cause_r != CAUSE_NONE,
                    !winding_r && leds_r == LED_STOP)

endmodule

### hw/rtl/preset_length_winder_control.sv
// Preset-length winder controller. Each request is one control-loop step
// (millisecond tick, encoder counts, button event) and yields exactly one
// result: mode, relay, LED bargraph, buzzer, saturating wound count and stop
// cause. A step is taken every clock cycle unless a result waits unaccepted
// on the output; a request passes through the input register, then the step
// logic that feeds the result register. While a result waits on the output,
// one more request can still enter the input register; after that the input
// stalls until the result is taken.
// Registers: 0 target pulses, 1 beep count, 2 beep length in ms ticks,
// 3 gap length in ms ticks; write them only while no step is in flight.
module preset_length_winder_control (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [plwc_pkg::CFG_AW-1:0] cfg_idx,
  input  logic [plwc_pkg::CFG_DW-1:0] cfg_wdata,
  plwc_in_if.sink                     in_ch,
  plwc_out_if.source                  out_ch
);
  import plwc_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  take;

  plwc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  plwc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  plwc_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

### verif/plwc_checker.sv
// Watches the step and result channels plus the register port, keeps its own
// model of the winder and compares every result against the oldest prediction.
module plwc_checker
  import plwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  plwc_in_if                in_ch,
  plwc_out_if               out_ch,
  output int                n_failed,
  output int                n_waiting,
  output int                n_steps,
  output int                n_button_stops,
  output int                n_target_stops
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        winding;
    logic        relay_drive;
    logic [3:0]  led_pattern;
    logic        buzzer_on;
    logic [23:0] wound_count;
    stop_cause_t stop_cause;
  } step_result_t;

  // register copy, tracked from the write port
  logic [TGT_BITS-1:0]   target_pulses;
  logic [3:0]            beep_total;
  logic [15:0]           beep_len;
  logic [7:0]            gap_len;

  // winder state
  logic                  mode_winding;
  logic [COUNT_BITS-1:0] pulse_cnt;
  logic [3:0]            beeps_left;
  logic                  in_gap;
  logic [7:0]            gap_elapsed;
  logic [15:0]           buzz_left;

  step_result_t step_results_q[$];
  step_result_t got;
  step_result_t want;
  int           errors = 0;
  int           steps = 0;
  int           button_stops = 0;
  int           target_stops = 0;

  // One control-loop step: tick, saturating count, then idle or winding logic
  function automatic step_result_t advance_winder(input logic tick, input logic [3:0] delta,
                                                  input logic press);
    step_result_t        r;
    logic [COUNT_BITS:0] sum;
    longint              capped;
    longint              seg;
    logic [3:0]          leds;
    stop_cause_t         cause;
    cause = CAUSE_NONE;
    if (tick) begin
      if (buzz_left != 0) buzz_left--;
      if (in_gap && gap_elapsed != GAP_MAX) gap_elapsed++;
    end
    sum = {1'b0, pulse_cnt} + delta;
    pulse_cnt = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    if (!mode_winding) begin
      // beep/gap sequencer only moves in idle
      if (in_gap) begin
        if (gap_elapsed >= gap_len) begin
          in_gap = 1'b0;
          if (beeps_left != 0) begin
            beeps_left--;
            buzz_left = beep_len;
          end
        end
      end else if (beeps_left != 0 && buzz_left == 0) begin
        in_gap = 1'b1;
        gap_elapsed = '0;
      end
      leds = LED_IDLE;
      // start press cancels beeping and clears the count
      if (press) begin
        beeps_left = '0;
        in_gap = 1'b0;
        buzz_left = '0;
        mode_winding = 1'b1;
        pulse_cnt = '0;
        leds = LED_START;
      end
    end else begin
      // bargraph of 4*min(count, target) / target
      capped = (pulse_cnt < target_pulses) ? pulse_cnt : target_pulses;
      seg = (target_pulses == 0) ? 0 : (capped * 4) / target_pulses;
      case (seg)
        0: leds = LED_BAR0;
        1: leds = LED_BAR1;
        2: leds = LED_BAR2;
        3: leds = LED_BAR3;
        default: leds = LED_BAR4;
      endcase
      // button wins over target when both happen
      if (press) cause = CAUSE_BUTTON;
      else if (pulse_cnt >= target_pulses) cause = CAUSE_TARGET;
      if (cause != CAUSE_NONE) begin
        mode_winding = 1'b0;
        leds = LED_STOP;
        beeps_left = (beep_total == 0) ? 4'd0 : beep_total - 4'd1;
        in_gap = 1'b0;
        buzz_left = beep_len;
      end
    end
    r.winding = mode_winding;
    r.relay_drive = mode_winding;
    r.led_pattern = leds;
    r.buzzer_on = (buzz_left != 0);
    r.wound_count = 24'(pulse_cnt);
    r.stop_cause = cause;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("result %0d: %s", steps, msg);
  endtask

  task automatic check_field(input string name, input logic [23:0] got_v,
                             input logic [23:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s is %0h, predicted %0h", name, got_v, want_v));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      target_pulses = TARGET_RST;
      beep_total = BEEP_TOT_RST;
      beep_len = BEEP_LEN_RST;
      gap_len = GAP_LEN_RST;
      mode_winding = 1'b0;
      pulse_cnt = '0;
      beeps_left = '0;
      in_gap = 1'b0;
      gap_elapsed = '0;
      buzz_left = '0;
      step_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_idx))
          REG_TARGET:   target_pulses = cfg_wdata[TGT_BITS-1:0];
          REG_BEEP_TOT: beep_total = cfg_wdata[3:0];
          REG_BEEP_LEN: beep_len = cfg_wdata[15:0];
          REG_GAP_LEN:  gap_len = cfg_wdata[7:0];
          default: ;
        endcase
      end
      // predict on each accepted request
      if (in_ch.valid && in_ch.ready)
        step_results_q.push_back(advance_winder(in_ch.ms_tick, in_ch.enc_delta,
                                                in_ch.button_press));
      // compare each accepted result with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        steps++;
        if (step_results_q.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = step_results_q.pop_front();
          got.winding = out_ch.winding;
          got.relay_drive = out_ch.relay_drive;
          got.led_pattern = out_ch.led_pattern;
          got.buzzer_on = out_ch.buzzer_on;
          got.wound_count = out_ch.wound_count;
          got.stop_cause = stop_cause_t'(out_ch.stop_cause);
          check_field("winding", got.winding, want.winding);
          check_field("relay_drive", got.relay_drive, want.relay_drive);
          check_field("led_pattern", got.led_pattern, want.led_pattern);
          check_field("buzzer_on", got.buzzer_on, want.buzzer_on);
          check_field("wound_count", got.wound_count, want.wound_count);
          check_field("stop_cause", got.stop_cause, want.stop_cause);
          if (want.stop_cause == CAUSE_BUTTON) button_stops++;
          if (want.stop_cause == CAUSE_TARGET) target_stops++;
        end
      end
    end
    n_failed <= errors;
    n_waiting <= step_results_q.size();
    n_steps <= steps;
    n_button_stops <= button_stops;
    n_target_stops <= target_stops;
  end

endmodule

### verif/tb.sv
// Stimulus and verdict for the winder controller; checking lives in plwc_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plwc_pkg::*;

  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_STEPS   = 150;
  localparam int STEADY_STEPS  = 200;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  plwc_in_if  in_ch ();
  plwc_out_if out_ch ();

  int n_failed;
  int n_waiting;
  int n_steps;
  int n_button_stops;
  int n_target_stops;

  bit                  steady_flow = 1'b0;
  logic [TGT_BITS-1:0] target_now = TARGET_RST;
  int                  settings_used = 1;
  int                  stall_cycles = 0;

  preset_length_winder_control u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  plwc_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .n_failed       (n_failed),
    .n_waiting      (n_waiting),
    .n_steps        (n_steps),
    .n_button_stops (n_button_stops),
    .n_target_stops (n_target_stops)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady_flow || ($urandom_range(99) >= 11);
    end
  end

  // stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no request or result moved for %0d cycles", stall_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one request, with an occasional gap in front of it
  task automatic send_step(input logic tick, input logic [3:0] delta, input logic press);
    if (!steady_flow && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ms_tick <= tick;
    in_ch.enc_delta <= delta;
    in_ch.button_press <= press;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // drain all results, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [TGT_BITS-1:0] tgt, input logic [3:0] total,
                                input logic [15:0] beep_ms, input logic [7:0] gap_ms);
    cfg_we <= 1'b1;
    cfg_idx <= REG_TARGET;
    cfg_wdata <= CFG_DW'(tgt);
    @(posedge clk);
    cfg_idx <= REG_BEEP_TOT;
    cfg_wdata <= CFG_DW'(total);
    @(posedge clk);
    cfg_idx <= REG_BEEP_LEN;
    cfg_wdata <= CFG_DW'(beep_ms);
    @(posedge clk);
    cfg_idx <= REG_GAP_LEN;
    cfg_wdata <= CFG_DW'(gap_ms);
    @(posedge clk);
    cfg_we <= 1'b0;
    target_now = tgt;
    settings_used++;
  endtask

  // Mostly full wind cycles: start, wind to target or an early press, then
  // idle steps through the beep sequence; some random noise bursts mixed in.
  task automatic run_random_phase(input int n_items);
    int         sent;
    int         k;
    longint     wound;
    logic [3:0] d;
    logic       tk;
    bit         done;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 6)) begin
          send_step(1'($urandom_range(1)), 4'($urandom_range(15)), 1'($urandom_range(1)));
          sent++;
        end
      end else begin
        send_step(1'($urandom_range(1)), 4'($urandom_range(15)), 1'b1);
        sent++;
        wound = 0;
        k = 0;
        done = 1'b0;
        while (!done) begin
          d = 4'(($urandom_range(1) == 0) ? $urandom_range(3) : $urandom_range(15));
          tk = 1'($urandom_range(1));
          if ($urandom_range(99) < 4 || k == 300) begin
            send_step(tk, d, 1'b1);
            done = 1'b1;
          end else begin
            send_step(tk, d, 1'b0);
            wound += d;
            if (wound >= target_now) done = 1'b1;
          end
          sent++;
          k++;
        end
        // coasting and beeping in idle; a short stretch gets cut by the next start
        repeat ($urandom_range(0, 60)) begin
          send_step($urandom_range(99) < 85, 4'($urandom_range(3)), 1'b0);
          sent++;
        end
      end
    end
  endtask

  // Long wind against the largest target, then a button stop and a restart
  task automatic run_steady_wind(input int n_items);
    send_step(1'($urandom_range(1)), 4'd15, 1'b1);
    for (int i = 0; i < n_items; i++)
      send_step(1'($urandom_range(1)), 4'($urandom_range(15)), 1'b0);
    repeat (4) send_step(1'b1, 4'd15, 1'b0);
    send_step(1'b0, 4'd3, 1'b1);
    send_step(1'b1, 4'd9, 1'b0);
    send_step(1'b1, 4'd0, 1'b1);
  endtask

  initial begin
    int                  r;
    logic [TGT_BITS-1:0] tgt;
    logic [15:0]         beep_ms;
    logic [7:0]          gap_ms;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_TARGET;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.ms_tick <= 1'b0;
    in_ch.enc_delta <= '0;
    in_ch.button_press <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle count, start, bargraph, button stop, cancel beeping
    send_step(1'b1, 4'd15, 1'b0);
    send_step(1'b0, 4'd0, 1'b1);
    send_step(1'b1, 4'd15, 1'b0);
    send_step(1'b0, 4'd8, 1'b0);
    send_step(1'b1, 4'd0, 1'b1);
    send_step(1'b1, 4'd5, 1'b0);
    send_step(1'b0, 4'd1, 1'b1);
    send_step(1'b1, 4'd2, 1'b1);

    // all-zero settings: target zero stops at once, zero beeps, zero gap,
    // then button and target together
    settle();
    write_settings('0, 4'd0, 16'd0, 8'd0);
    send_step(1'b0, 4'd0, 1'b1);
    send_step(1'b1, 4'd3, 1'b0);
    repeat (4) send_step(1'b1, 4'd0, 1'b0);
    send_step(1'b1, 4'd15, 1'b1);
    send_step(1'b0, 4'd15, 1'b1);
    repeat (2) send_step(1'b1, 4'd7, 1'b0);

    // tiny target: walk the bargraph one step at a time into a target stop
    settle();
    write_settings(24'd4, 4'd15, 16'd2, 8'd1);
    send_step(1'b1, 4'd0, 1'b1);
    send_step(1'b0, 4'd1, 1'b0);
    send_step(1'b0, 4'd1, 1'b0);
    send_step(1'b1, 4'd1, 1'b0);
    send_step(1'b1, 4'd1, 1'b0);
    repeat (2) send_step(1'b1, 4'd0, 1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      r = $urandom_range(9);
      if (r == 0) tgt = '0;
      else if (r == 1) tgt = 24'd1;
      else if (r == 2) tgt = TGT_BITS'($urandom_range(2, 8));
      else tgt = TGT_BITS'($urandom_range(9, 200));
      r = $urandom_range(9);
      beep_ms = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 8));
      r = $urandom_range(9);
      gap_ms = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom_range(1, 6));
      write_settings(tgt, 4'($urandom_range(15)), beep_ms, gap_ms);
      run_random_phase(PHASE_STEPS);
    end

    // largest settings, with neither side idling for the whole stretch
    settle();
    write_settings(24'hFFFFFF, 4'd15, 16'hFFFF, 8'hFF);
    steady_flow <= 1'b1;
    run_steady_wind(STEADY_STEPS);
    steady_flow <= 1'b0;
    settle();

    $display("%0d steps checked under %0d register settings", n_steps, settings_used);
    $display("stops: %0d by button, %0d by target, plus a long wind with no idling",
             n_button_stops, n_target_stops);
    if (n_failed == 0 && n_waiting == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
